/* rtl/rsff_pkg.sv */
// Shared types and constants of the raw socket frame filter.
`timescale 1ns / 1ps

package rsff_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0] CountSat = 11'h7FF;
  localparam logic [CountW-1:0] EthHdr = 11'd14;
  localparam logic [CountW-1:0] Ipv4MinFrame = 11'd34;
  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeAll = 16'd3;
  localparam logic [7:0] BcastByte = 8'd255;
  localparam logic [5:0] IhlMin = 6'd20;
  localparam logic [3:0] IpVersion4 = 4'd4;
  localparam logic [7:0] IfxAny = 8'd0;
  localparam logic [7:0] IfxLocal = 8'd2;

  localparam logic [1:0] ModeLinkRaw = 2'd0;
  localparam logic [1:0] ModeLinkDgram = 2'd1;
  localparam logic [1:0] ModeIpRaw = 2'd2;

  localparam logic [1:0] KindHost = 2'd0;
  localparam logic [1:0] KindMulticast = 2'd1;
  localparam logic [1:0] KindBroadcast = 2'd2;

  localparam logic [CfgIdxW-1:0] RegSocketMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegProtocolMatch = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInterfaceIndex = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLocalAddress = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRemoteAddress = 3'd4;

  typedef struct packed {
    logic [1:0]  socket_mode;
    logic [15:0] protocol_match;
    logic [7:0]  interface_index;
    logic [31:0] local_address;
    logic [31:0] remote_address;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] len;
    logic [7:0]        first_dest;
    logic [47:0]       src_mac;
    logic [15:0]       ether_type;
    logic [7:0]        ver_ihl;
    logic [15:0]       ip_total;
    logic [7:0]        ip_proto;
    logic [31:0]       ip_src;
    logic [31:0]       ip_dst;
  } frame_rec_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  payload_offset;
    logic [10:0] payload_length;
    logic [1:0]  packet_kind;
    logic [15:0] ether_type;
    logic [47:0] source_mac;
    logic [31:0] source_address;
  } result_t;

endpackage

/* rtl/rsff_if.sv */
// Stream and configuration channel interfaces of the raw socket frame filter.
`timescale 1ns / 1ps

interface rsff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface rsff_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  payload_offset;
  logic [10:0] payload_length;
  logic [1:0]  packet_kind;
  logic [15:0] ether_type;
  logic [47:0] source_mac;
  logic [31:0] source_address;

  modport source (output valid, output accepted, output payload_offset,
                  output payload_length, output packet_kind, output ether_type,
                  output source_mac, output source_address, input ready);
  modport sink (input valid, input accepted, input payload_offset,
                input payload_length, input packet_kind, input ether_type,
                input source_mac, input source_address, output ready);
endinterface

interface rsff_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rsff_pkg::CfgIdxW-1:0]  index;
  logic [rsff_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/rsff_front.sv */
// Front end: byte counter and header field capture, one record per frame.
`timescale 1ns / 1ps

module rsff_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [7:0]           frame_byte_i,
  input  logic                 last_byte_i,
  output logic                 ready_o,
  input  logic                 full_i,
  output logic                 push_o,
  output rsff_pkg::frame_rec_t rec_o
);

  rsff_pkg::frame_rec_t rec_q, rec_d;
  logic                 accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    rec_d = rec_q;
    case (rec_q.len) inside
      11'd0: rec_d.first_dest = frame_byte_i;
      [11'd6:11'd11]: rec_d.src_mac = {rec_q.src_mac[39:0], frame_byte_i};
      [11'd12:11'd13]: rec_d.ether_type = {rec_q.ether_type[7:0], frame_byte_i};
      11'd14: rec_d.ver_ihl = frame_byte_i;
      [11'd16:11'd17]: rec_d.ip_total = {rec_q.ip_total[7:0], frame_byte_i};
      11'd23: rec_d.ip_proto = frame_byte_i;
      [11'd26:11'd29]: rec_d.ip_src = {rec_q.ip_src[23:0], frame_byte_i};
      [11'd30:11'd33]: rec_d.ip_dst = {rec_q.ip_dst[23:0], frame_byte_i};
      default: ;
    endcase
    if (rec_q.len != rsff_pkg::CountSat) begin
      rec_d.len = rec_q.len + 11'd1;
    end
  end

  assign push_o = accept && last_byte_i;
  assign rec_o  = rec_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        rec_q <= '0;
      end else begin
        rec_q <= rec_d;
      end
    end
  end

endmodule

/* rtl/rsff_queue.sv */
// Two-entry record queue between the capture front and the filter back end.
`timescale 1ns / 1ps

module rsff_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsff_pkg::frame_rec_t rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output rsff_pkg::frame_rec_t rec_o
);

  rsff_pkg::frame_rec_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_pop;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign rec_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q;
    if (push_i && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

/* rtl/rsff_back.sv */
// Back end: filter decision on a captured frame and the registered result.
`timescale 1ns / 1ps

module rsff_back #(
  parameter int unsigned MAX_FRAME_BYTES = 1514
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsff_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  rsff_pkg::frame_rec_t q_rec_i,
  output logic                 q_pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output rsff_pkg::result_t    res_o
);

  localparam logic [rsff_pkg::CountW-1:0] MaxLen = rsff_pkg::CountW'(MAX_FRAME_BYTES);

  rsff_pkg::result_t res_q, res_d;
  logic              valid_q;
  logic [10:0]       offset;
  logic [10:0]       room;
  logic [5:0]        ihl;
  logic              len_ok, link_ok, ip_ok, ok;

  assign q_pop_o = q_valid_i && (!valid_q || res_ready_i);

  always_comb begin
    offset  = (cfg_i.socket_mode == rsff_pkg::ModeLinkRaw) ? 11'd0 : rsff_pkg::EthHdr;
    room    = q_rec_i.len - rsff_pkg::EthHdr;
    ihl     = {q_rec_i.ver_ihl[3:0], 2'b00};
    len_ok  = (q_rec_i.len >= rsff_pkg::EthHdr) && (q_rec_i.len <= MaxLen);
    link_ok = (cfg_i.protocol_match != 16'd0)
           && ((cfg_i.protocol_match == rsff_pkg::EtypeAll)
               || (cfg_i.protocol_match == q_rec_i.ether_type))
           && ((cfg_i.interface_index == rsff_pkg::IfxAny)
               || (cfg_i.interface_index == rsff_pkg::IfxLocal));
    ip_ok   = (q_rec_i.ether_type == rsff_pkg::EtypeIpv4)
           && (q_rec_i.len >= rsff_pkg::Ipv4MinFrame)
           && (q_rec_i.ver_ihl[7:4] == rsff_pkg::IpVersion4)
           && ({8'd0, q_rec_i.ip_proto} == cfg_i.protocol_match)
           && (ihl >= rsff_pkg::IhlMin)
           && (q_rec_i.ip_total >= {10'd0, ihl})
           && (q_rec_i.ip_total <= {5'd0, room})
           && ((cfg_i.local_address == 32'd0) || (cfg_i.local_address == q_rec_i.ip_dst))
           && ((cfg_i.remote_address == 32'd0) || (cfg_i.remote_address == q_rec_i.ip_src));
    ok      = len_ok && ((((cfg_i.socket_mode == rsff_pkg::ModeLinkRaw)
                          || (cfg_i.socket_mode == rsff_pkg::ModeLinkDgram)) && link_ok)
                         || ((cfg_i.socket_mode == rsff_pkg::ModeIpRaw) && ip_ok));

    res_d = '0;
    if (ok) begin
      res_d.accepted       = 1'b1;
      res_d.payload_offset = offset[3:0];
      res_d.ether_type     = q_rec_i.ether_type;
      res_d.source_mac     = q_rec_i.src_mac;
      if (cfg_i.socket_mode == rsff_pkg::ModeIpRaw) begin
        res_d.payload_length = q_rec_i.ip_total[10:0];
        res_d.source_address = q_rec_i.ip_src;
      end else begin
        res_d.payload_length = q_rec_i.len - offset;
      end
      if (q_rec_i.first_dest == rsff_pkg::BcastByte) begin
        res_d.packet_kind = rsff_pkg::KindBroadcast;
      end else if (q_rec_i.first_dest[0]) begin
        res_d.packet_kind = rsff_pkg::KindMulticast;
      end else begin
        res_d.packet_kind = rsff_pkg::KindHost;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/raw_socket_frame_filter_unit.sv */
// Top level of the raw socket frame filter: config registers, front, queue, back.
`timescale 1ns / 1ps
//
// Frame bytes enter on in_if, destination MAC first, last_byte set on the
// final byte. One byte is taken per cycle while in_if.ready is high, with
// no gaps between frames. Each frame yields exactly one result request on
// out_if, after its record passes through the queue and the output register.
// The front captures header fields and pushes one record per frame into a
// two-entry queue; the back evaluates the filter and holds the result in an
// output register until out_if takes it. When out_if stalls, results pile
// up in the queue; in_if.ready drops only while the queue holds two
// records, so a stalled receiver pauses input after three pending frames,
// one in the output register and two in the queue.
// cfg_if writes one of five registers per cycle and is always ready;
// write only while no frame is in flight. Indexes beyond the list are
// ignored. Reset clears the registers, the byte count, the captured fields,
// the queue and the output valid. Frames longer than MAX_FRAME_BYTES are
// rejected; the byte count saturates at 2047.
//
module raw_socket_frame_filter_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 1514
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsff_in_if.sink      in_if,
  rsff_out_if.source   out_if,
  rsff_cfg_if.sink     cfg_if
);

  rsff_pkg::cfg_t       cfg_q;
  rsff_pkg::frame_rec_t push_rec, head_rec;
  rsff_pkg::result_t    res;
  logic                 push, full, head_valid, pop;
  logic                 cfg_we;

  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid && cfg_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_if.index)
        rsff_pkg::RegSocketMode:     cfg_q.socket_mode     <= cfg_if.data[1:0];
        rsff_pkg::RegProtocolMatch:  cfg_q.protocol_match  <= cfg_if.data[15:0];
        rsff_pkg::RegInterfaceIndex: cfg_q.interface_index <= cfg_if.data[7:0];
        rsff_pkg::RegLocalAddress:   cfg_q.local_address   <= cfg_if.data;
        rsff_pkg::RegRemoteAddress:  cfg_q.remote_address  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  rsff_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_if.valid),
    .frame_byte_i (in_if.frame_byte),
    .last_byte_i  (in_if.last_byte),
    .ready_o      (in_if.ready),
    .full_i       (full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  rsff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  rsff_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (head_valid),
    .q_rec_i     (head_rec),
    .q_pop_o     (pop),
    .res_valid_o (out_if.valid),
    .res_ready_i (out_if.ready),
    .res_o       (res)
  );

  assign out_if.accepted       = res.accepted;
  assign out_if.payload_offset = res.payload_offset;
  assign out_if.payload_length = res.payload_length;
  assign out_if.packet_kind    = res.packet_kind;
  assign out_if.ether_type     = res.ether_type;
  assign out_if.source_mac     = res.source_mac;
  assign out_if.source_address = res.source_address;

endmodule

/* rtl/rsff_checker.sv */
// Port-level assertions on the result channel of the raw socket frame filter.
`timescale 1ns / 1ps

module rsff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        accepted_i,
  input logic [3:0]  payload_offset_i,
  input logic [10:0] payload_length_i,
  input logic [1:0]  packet_kind_i,
  input logic [15:0] ether_type_i,
  input logic [47:0] source_mac_i,
  input logic [31:0] source_address_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(accepted_i)
      && $stable(payload_length_i) && $stable(source_mac_i))
    else $error("result request changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !accepted_i |-> payload_offset_i == 4'd0 && payload_length_i == 11'd0
      && packet_kind_i == 2'd0 && ether_type_i == 16'd0 && source_mac_i == 48'd0
      && source_address_i == 32'd0)
    else $error("rejected frame carries nonzero fields");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> payload_offset_i == 4'd0 || payload_offset_i == 4'd14)
    else $error("payload offset out of range");

  a_link_raw_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i && payload_offset_i == 4'd0 |-> source_address_i == 32'd0)
    else $error("link raw frame carries an IPv4 source");

endmodule

bind raw_socket_frame_filter_unit rsff_checker u_rsff_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .accepted_i       (out_if.accepted),
  .payload_offset_i (out_if.payload_offset),
  .payload_length_i (out_if.payload_length),
  .packet_kind_i    (out_if.packet_kind),
  .ether_type_i     (out_if.ether_type),
  .source_mac_i     (out_if.source_mac),
  .source_address_i (out_if.source_address)
);
